// File: hdl/kwb_pkg.sv
// Shared constants, types and register codes of the keyed watermark blend.
package kwb_pkg;

  // Store geometry and coordinate width.
  localparam int MAX_WM_WIDTH  = 256;
  localparam int MAX_WM_HEIGHT = 256;
  localparam int COORD_BITS    = 12;

  // Pixel and step formats.
  localparam int CH_BITS   = 8;
  localparam int PIX_BITS  = 3 * CH_BITS;
  localparam int STEP_BITS = 24;
  localparam int FRAC_BITS = 16;
  localparam int SIZE_BITS = 9;

  // Derived widths.
  localparam int WX_BITS     = (MAX_WM_WIDTH > 1) ? $clog2(MAX_WM_WIDTH) : 1;
  localparam int WY_BITS     = (MAX_WM_HEIGHT > 1) ? $clog2(MAX_WM_HEIGHT) : 1;
  localparam int STORE_DEPTH = MAX_WM_WIDTH * MAX_WM_HEIGHT;
  localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PROD_BITS   = COORD_BITS + STEP_BITS;
  localparam int RND_BITS    = PROD_BITS + 1 - FRAC_BITS;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_FIELD_BITS = 2 * COORD_BITS + PIX_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((PIX_BITS + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_OFFSET_X  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_OFFSET_Y  = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_WM_WIDTH  = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_WM_HEIGHT = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_X_STEP    = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_Y_STEP    = 3'd5;

  // Register reset values.
  localparam logic [SIZE_BITS-1:0] RST_WM_SIZE = 9'd256;
  localparam logic [STEP_BITS-1:0] RST_STEP    = 24'd65536;

  // Action codes carried in tuser.
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_PROCESS = 1'b1;

  // Configuration register set.
  typedef struct packed {
    logic [COORD_BITS-1:0] offset_x;
    logic [COORD_BITS-1:0] offset_y;
    logic [SIZE_BITS-1:0]  wm_width;
    logic [SIZE_BITS-1:0]  wm_height;
    logic [STEP_BITS-1:0]  x_step;
    logic [STEP_BITS-1:0]  y_step;
  } cfg_t;

  // One input request; rgb holds red in the top byte, blue in the bottom.
  typedef struct packed {
    logic                  action;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [PIX_BITS-1:0]   rgb;
  } item_t;

  // Store access issued by the mapping pipeline.
  typedef struct packed {
    logic                 valid;
    logic                 action;
    logic                 hit;
    logic [ADDR_BITS-1:0] addr;
    logic [PIX_BITS-1:0]  rgb;
  } req_t;

endpackage

// File: hdl/kwb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module kwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/kwb_cfg.sv
// APB-style configuration registers of the keyed watermark blend.
module kwb_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [kwb_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [kwb_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [kwb_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output kwb_pkg::cfg_t                       cfg
);
  import kwb_pkg::*;

  cfg_t                    cfg_r;
  logic [REG_IDX_BITS-1:0] idx;
  logic                    wr;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_ADDR_BITS-1:2];
  assign wr     = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_x  <= '0;
      cfg_r.offset_y  <= '0;
      cfg_r.wm_width  <= RST_WM_SIZE;
      cfg_r.wm_height <= RST_WM_SIZE;
      cfg_r.x_step    <= RST_STEP;
      cfg_r.y_step    <= RST_STEP;
    end else if (wr) begin
      case (idx)
        REG_OFFSET_X:  cfg_r.offset_x  <= pwdata[COORD_BITS-1:0];
        REG_OFFSET_Y:  cfg_r.offset_y  <= pwdata[COORD_BITS-1:0];
        REG_WM_WIDTH:  cfg_r.wm_width  <= pwdata[SIZE_BITS-1:0];
        REG_WM_HEIGHT: cfg_r.wm_height <= pwdata[SIZE_BITS-1:0];
        REG_X_STEP:    cfg_r.x_step    <= pwdata[STEP_BITS-1:0];
        REG_Y_STEP:    cfg_r.y_step    <= pwdata[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer; unused addresses read as zero.
  always_comb begin
    case (idx)
      REG_OFFSET_X:  prdata = CFG_DATA_BITS'(cfg_r.offset_x);
      REG_OFFSET_Y:  prdata = CFG_DATA_BITS'(cfg_r.offset_y);
      REG_WM_WIDTH:  prdata = CFG_DATA_BITS'(cfg_r.wm_width);
      REG_WM_HEIGHT: prdata = CFG_DATA_BITS'(cfg_r.wm_height);
      REG_X_STEP:    prdata = CFG_DATA_BITS'(cfg_r.x_step);
      REG_Y_STEP:    prdata = CFG_DATA_BITS'(cfg_r.y_step);
      default:       prdata = '0;
    endcase
  end

endmodule

// File: hdl/kwb_map.sv
// Coordinate mapping pipeline: placement offset, step scaling, bounds and store address.
module kwb_map (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           item_valid,
  input  kwb_pkg::item_t item,
  input  kwb_pkg::cfg_t  cfg,
  output kwb_pkg::req_t  req
);
  import kwb_pkg::*;

  // Stage 1: offsets from the placement origin.
  logic                  s1_valid_r;
  item_t                 s1_item_r;
  logic                  s1_inside_r;
  logic [COORD_BITS-1:0] s1_dx_r;
  logic [COORD_BITS-1:0] s1_dy_r;

  // Stage 2: products with the steps.
  logic                  s2_valid_r;
  item_t                 s2_item_r;
  logic                  s2_inside_r;
  logic [PROD_BITS-1:0]  s2_px_r;
  logic [PROD_BITS-1:0]  s2_py_r;

  // Stage 3: rounded watermark coordinates and bounds check.
  logic                  s3_valid_r;
  item_t                 s3_item_r;
  logic                  s3_hit_r;
  logic [WX_BITS-1:0]    s3_wx_r;
  logic [WY_BITS-1:0]    s3_wy_r;

  // Stage 4: store request.
  req_t                  req_r;

  logic [PROD_BITS:0]    sum_x;
  logic [PROD_BITS:0]    sum_y;
  logic [RND_BITS-1:0]   rnd_x;
  logic [RND_BITS-1:0]   rnd_y;
  logic                  hit_nxt;
  logic [WX_BITS-1:0]    wx_nxt;
  logic [WY_BITS-1:0]    wy_nxt;

  // Round half up, then check against the used area; loads check the store bounds.
  always_comb begin
    sum_x = {1'b0, s2_px_r} + (PROD_BITS + 1)'(1 << (FRAC_BITS - 1));
    sum_y = {1'b0, s2_py_r} + (PROD_BITS + 1)'(1 << (FRAC_BITS - 1));
    rnd_x = sum_x[PROD_BITS:FRAC_BITS];
    rnd_y = sum_y[PROD_BITS:FRAC_BITS];
    if (s2_item_r.action == ACT_LOAD) begin
      hit_nxt = (32'(s2_item_r.col) < MAX_WM_WIDTH) && (32'(s2_item_r.row) < MAX_WM_HEIGHT);
      wx_nxt  = WX_BITS'(s2_item_r.col);
      wy_nxt  = WY_BITS'(s2_item_r.row);
    end else begin
      hit_nxt = s2_inside_r
             && (32'(rnd_x) < 32'(cfg.wm_width)) && (32'(rnd_x) < MAX_WM_WIDTH)
             && (32'(rnd_y) < 32'(cfg.wm_height)) && (32'(rnd_y) < MAX_WM_HEIGHT);
      wx_nxt  = WX_BITS'(rnd_x);
      wy_nxt  = WY_BITS'(rnd_y);
    end
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      req_r.valid <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= item_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      req_r.valid <= s3_valid_r;
    end
  end

  // Payload of the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r    <= item;
      s1_inside_r  <= (item.col >= cfg.offset_x) && (item.row >= cfg.offset_y);
      s1_dx_r      <= item.col - cfg.offset_x;
      s1_dy_r      <= item.row - cfg.offset_y;

      s2_item_r    <= s1_item_r;
      s2_inside_r  <= s1_inside_r;
      s2_px_r      <= PROD_BITS'(s1_dx_r) * PROD_BITS'(cfg.x_step);
      s2_py_r      <= PROD_BITS'(s1_dy_r) * PROD_BITS'(cfg.y_step);

      s3_item_r    <= s2_item_r;
      s3_hit_r     <= hit_nxt;
      s3_wx_r      <= wx_nxt;
      s3_wy_r      <= wy_nxt;

      req_r.action <= s3_item_r.action;
      req_r.hit    <= s3_hit_r;
      req_r.addr   <= ADDR_BITS'(32'(s3_wy_r) * MAX_WM_WIDTH + 32'(s3_wx_r));
      req_r.rgb    <= s3_item_r.rgb;
    end
  end

  assign req = req_r;

endmodule

// File: hdl/keyed_watermark_blend.sv
// Top level of the keyed watermark blend: input skid, store, blend and output register.
//
//   Channel  Direction  Ports                         Contents
//   in_      slave      tvalid tready tdata tuser     load or process request
//   out_     master     tvalid tready tdata tuser     blended pixel result
//   cfg_     APB slave  psel penable pwrite paddr ... placement and step registers
//
// One request is taken every cycle while the pipeline moves; a process request passes three mapping
// stages, the store request, the store read and the output register before its result is presented.
// Loads write the store at the same stage where process requests read it, so order holds.
// Reset clears the pipeline valid bits and the registers; the store itself is not cleared.
// While a result waits on out_tready the pipeline holds and one more request enters the skid.
module keyed_watermark_blend (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // col, row, red, green, blue (lowest bits first)
  input  logic [kwb_pkg::IN_DATA_BITS-1:0]    in_tdata,
  // action
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_red, out_green, out_blue (lowest bits first)
  output logic [kwb_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  // blended
  output logic                                out_tuser,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [kwb_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [kwb_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic [kwb_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                cfg_pready
);
  import kwb_pkg::*;

  cfg_t                cfg;
  item_t               in_item;
  item_t               head_item;
  logic                head_valid;
  item_t               skid_r;
  logic                skid_valid_r;
  logic                en;
  req_t                req;
  logic                ram_we;
  logic                ram_re;
  logic [PIX_BITS-1:0] ram_rdata;

  logic                s5_valid_r;
  logic                s5_proc_r;
  logic                s5_hit_r;
  logic [PIX_BITS-1:0] s5_rgb_r;

  logic                     out_valid_r;
  logic [OUT_DATA_BITS-1:0] out_data_r;
  logic                     out_blend_r;
  logic                     blend_nxt;
  logic [CH_BITS:0]         sum_r;
  logic [CH_BITS:0]         sum_g;
  logic [CH_BITS:0]         sum_b;

  // Configuration registers.
  kwb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Unpack the input request.
  assign in_item.action = in_tuser;
  assign in_item.col    = in_tdata[COORD_BITS-1:0];
  assign in_item.row    = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_item.rgb    = {in_tdata[2*COORD_BITS+CH_BITS-1:2*COORD_BITS],
                           in_tdata[2*COORD_BITS+2*CH_BITS-1:2*COORD_BITS+CH_BITS],
                           in_tdata[2*COORD_BITS+3*CH_BITS-1:2*COORD_BITS+2*CH_BITS]};

  // The whole pipeline moves whenever the output register can take a result.
  assign en = !out_valid_r || out_tready;

  // Skid stage: catches one request while the pipeline is held.
  assign in_tready  = !skid_valid_r;
  assign head_valid = skid_valid_r || in_tvalid;
  assign head_item  = skid_valid_r ? skid_r : in_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else if (en) begin
      skid_valid_r <= 1'b0;
    end else if (in_tvalid && !skid_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_tvalid && !skid_valid_r) begin
      skid_r <= in_item;
    end
  end

  // Coordinate mapping.
  kwb_map u_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .item_valid (head_valid),
    .item       (head_item),
    .cfg        (cfg),
    .req        (req)
  );

  // Watermark store: loads write, process requests read, both at the request stage.
  assign ram_we = en && req.valid && (req.action == ACT_LOAD) && req.hit;
  assign ram_re = en;

  kwb_ram #(
    .WIDTH (PIX_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req.addr),
    .wdata (req.rgb),
    .re    (ram_re),
    .raddr (req.addr),
    .rdata (ram_rdata)
  );

  // Stage alongside the store read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_proc_r <= (req.action == ACT_PROCESS);
      s5_hit_r  <= req.hit;
      s5_rgb_r  <= req.rgb;
    end
  end

  // Colour key and floor average of each channel.
  always_comb begin
    blend_nxt = s5_hit_r && (ram_rdata != '0);
    sum_r = {1'b0, s5_rgb_r[3*CH_BITS-1:2*CH_BITS]} + {1'b0, ram_rdata[3*CH_BITS-1:2*CH_BITS]};
    sum_g = {1'b0, s5_rgb_r[2*CH_BITS-1:CH_BITS]} + {1'b0, ram_rdata[2*CH_BITS-1:CH_BITS]};
    sum_b = {1'b0, s5_rgb_r[CH_BITS-1:0]} + {1'b0, ram_rdata[CH_BITS-1:0]};
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s5_valid_r && s5_proc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_blend_r <= blend_nxt;
      if (blend_nxt) begin
        out_data_r <= OUT_DATA_BITS'({sum_b[CH_BITS:1], sum_g[CH_BITS:1], sum_r[CH_BITS:1]});
      end else begin
        out_data_r <= OUT_DATA_BITS'({s5_rgb_r[CH_BITS-1:0],
                                      s5_rgb_r[2*CH_BITS-1:CH_BITS],
                                      s5_rgb_r[3*CH_BITS-1:2*CH_BITS]});
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_blend_r;

  // A request taken while the pipeline is held must land in the skid.
  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !en |=> skid_valid_r)
    else $error("request taken during a hold was not caught by the skid");

  // A process request leaving the store stage must show up as a result.
  a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
    en && s5_valid_r && s5_proc_r |=> out_tvalid)
    else $error("process request produced no result");

  // A held result with a request taken fills the skid, so the input closes.
  a_input_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && in_tvalid && in_tready |=> !in_tready)
    else $error("input stayed open with a result and a request both waiting");

  // Only a loading request may write the store, and only when the pipeline moves.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (req.valid && req.action == ACT_LOAD && en))
    else $error("store written without a valid load request");

endmodule

// File: dv/kwb_blend_checker.sv
// Checker for the keyed watermark blend: mirrors the registers and the store, predicts results.
module kwb_blend_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  // col, row, red, green, blue (lowest bits first)
  input  logic [kwb_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // action
  input  logic                              in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  // out_red, out_green, out_blue (lowest bits first)
  input  logic [kwb_pkg::OUT_DATA_BITS-1:0] out_tdata,
  // blended
  input  logic                              out_tuser,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [kwb_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [kwb_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  input  logic                              cfg_pready,
  output int                                fail_count,
  output int                                pending_results
);
  import kwb_pkg::*;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
    logic               blended;
  } blend_result_t;

  // Local copy of the placement registers and of the watermark image.
  cfg_t                placement;
  logic [PIX_BITS-1:0] wm_image [STORE_DEPTH];
  blend_result_t       expected_pixels [$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("%0t: mismatch in %s: expected %0h, got %0h", $time, what, want, got);
    fail_count++;
  endtask

  // Works out the output pixel of one process request.
  function automatic blend_result_t blend_pixel(item_t req);
    logic [63:0]         wx;
    logic [63:0]         wy;
    int                  lim_x;
    int                  lim_y;
    logic [PIX_BITS-1:0] wm;
    blend_result_t       res;
    res.red     = req.rgb[23:16];
    res.green   = req.rgb[15:8];
    res.blue    = req.rgb[7:0];
    res.blended = 1'b0;
    if (req.col >= placement.offset_x && req.row >= placement.offset_y) begin
      // Nearest-neighbour mapping with half-up rounding of offset times step.
      wx = (64'(req.col - placement.offset_x) * 64'(placement.x_step) + 64'h8000) >> FRAC_BITS;
      wy = (64'(req.row - placement.offset_y) * 64'(placement.y_step) + 64'h8000) >> FRAC_BITS;
      lim_x = (placement.wm_width < MAX_WM_WIDTH) ? int'(placement.wm_width) : MAX_WM_WIDTH;
      lim_y = (placement.wm_height < MAX_WM_HEIGHT) ? int'(placement.wm_height) : MAX_WM_HEIGHT;
      if (wx < 64'(lim_x) && wy < 64'(lim_y)) begin
        wm = wm_image[ADDR_BITS'(wy * MAX_WM_WIDTH + wx)];
        // Pure black is the key colour and leaves the source alone.
        if (wm != '0) begin
          res.red     = CH_BITS'((9'(req.rgb[23:16]) + 9'(wm[23:16])) >> 1);
          res.green   = CH_BITS'((9'(req.rgb[15:8]) + 9'(wm[15:8])) >> 1);
          res.blue    = CH_BITS'((9'(req.rgb[7:0]) + 9'(wm[7:0])) >> 1);
          res.blended = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // Register writes, requests and results, all seen at the rising edge.
  always @(posedge clk) begin
    item_t         req;
    blend_result_t got;
    blend_result_t want;
    if (!rst_n) begin
      placement.offset_x  = '0;
      placement.offset_y  = '0;
      placement.wm_width  = RST_WM_SIZE;
      placement.wm_height = RST_WM_SIZE;
      placement.x_step    = RST_STEP;
      placement.y_step    = RST_STEP;
      expected_pixels.delete();
    end else begin
      // Register write at the access phase.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_ADDR_BITS-1:2])
          REG_OFFSET_X:  placement.offset_x  = cfg_pwdata[COORD_BITS-1:0];
          REG_OFFSET_Y:  placement.offset_y  = cfg_pwdata[COORD_BITS-1:0];
          REG_WM_WIDTH:  placement.wm_width  = cfg_pwdata[SIZE_BITS-1:0];
          REG_WM_HEIGHT: placement.wm_height = cfg_pwdata[SIZE_BITS-1:0];
          REG_X_STEP:    placement.x_step    = cfg_pwdata[STEP_BITS-1:0];
          REG_Y_STEP:    placement.y_step    = cfg_pwdata[STEP_BITS-1:0];
          default: ;
        endcase
      end

      // Accepted request: loads fill the image, process requests queue a result.
      if (in_tvalid && in_tready) begin
        req.action = in_tuser;
        req.col    = in_tdata[COORD_BITS-1:0];
        req.row    = in_tdata[2*COORD_BITS-1:COORD_BITS];
        req.rgb    = {in_tdata[2*COORD_BITS +: CH_BITS],
                      in_tdata[2*COORD_BITS+CH_BITS +: CH_BITS],
                      in_tdata[2*COORD_BITS+2*CH_BITS +: CH_BITS]};
        if (req.action == ACT_LOAD) begin
          if (req.col < MAX_WM_WIDTH && req.row < MAX_WM_HEIGHT) begin
            wm_image[ADDR_BITS'(32'(req.row) * MAX_WM_WIDTH + 32'(req.col))] = req.rgb;
          end
        end else begin
          expected_pixels.push_back(blend_pixel(req));
        end
      end

      // Accepted result is compared with the oldest prediction.
      if (out_tvalid && out_tready) begin
        got.red     = out_tdata[0 +: CH_BITS];
        got.green   = out_tdata[CH_BITS +: CH_BITS];
        got.blue    = out_tdata[2*CH_BITS +: CH_BITS];
        got.blended = out_tuser;
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected result", 32'd0, 32'(got));
        end else begin
          want = expected_pixels.pop_front();
          if (got.red !== want.red) report_mismatch("out_red", 32'(want.red), 32'(got.red));
          if (got.green !== want.green) begin
            report_mismatch("out_green", 32'(want.green), 32'(got.green));
          end
          if (got.blue !== want.blue) report_mismatch("out_blue", 32'(want.blue), 32'(got.blue));
          if (got.blended !== want.blended) begin
            report_mismatch("blended", 32'(want.blended), 32'(got.blended));
          end
        end
      end
    end
    pending_results = expected_pixels.size();
  end

endmodule

// File: dv/keyed_watermark_blend_tb.sv
// Testbench top for the keyed watermark blend: stimulus, configuration phases and verdict.
module keyed_watermark_blend_tb;
  import kwb_pkg::*;

  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 2000;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;
  logic                     in_tuser;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tuser;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;
  int                       fail_count;
  int                       pending_results;

  // Placement currently programmed, and which image entries hold a loaded pixel.
  cfg_t plan;
  bit   written_map [STORE_DEPTH];
  bit   calm = 1'b0;
  int   stall_cycles = 0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  keyed_watermark_blend i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  kwb_blend_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_pready      (cfg_pready),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Result side back-pressure, switched off during the calm stretch.
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 31);
  end

  // Watchdog: too long without any request, result or register write ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[keyed_watermark_blend] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic cfg_t make_placement(int ox, int oy, int w, int h, int xs, int ys);
    cfg_t c;
    c.offset_x  = COORD_BITS'(ox);
    c.offset_y  = COORD_BITS'(oy);
    c.wm_width  = SIZE_BITS'(w);
    c.wm_height = SIZE_BITS'(h);
    c.x_step    = STEP_BITS'(xs);
    c.y_step    = STEP_BITS'(ys);
    return c;
  endfunction

  // Mostly small offsets and sizes so that the placed region is reached often.
  function automatic cfg_t random_placement();
    int ox;
    int oy;
    ox = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(600);
    oy = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(600);
    return make_placement(ox, oy,
      ($urandom_range(3) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 32),
      ($urandom_range(3) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 32),
      ($urandom_range(3) == 0) ? $urandom_range(65536, 24'hFFFFFF) : $urandom_range(65536, 262144),
      ($urandom_range(3) == 0) ? $urandom_range(65536, 24'hFFFFFF) : $urandom_range(65536, 262144));
  endfunction

  // Pixel colours with the black key and full white showing up often.
  function automatic logic [PIX_BITS-1:0] random_colour();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return PIX_BITS'($urandom);
  endfunction

  // Image entry that a process request reads under the current placement, or -1.
  function automatic int stored_index(logic [COORD_BITS-1:0] col, logic [COORD_BITS-1:0] row);
    longint wx;
    longint wy;
    longint lx;
    longint ly;
    if (col < plan.offset_x || row < plan.offset_y) return -1;
    wx = (longint'(col - plan.offset_x) * longint'(plan.x_step) + 32768) >>> FRAC_BITS;
    wy = (longint'(row - plan.offset_y) * longint'(plan.y_step) + 32768) >>> FRAC_BITS;
    lx = (plan.wm_width < MAX_WM_WIDTH) ? longint'(plan.wm_width) : MAX_WM_WIDTH;
    ly = (plan.wm_height < MAX_WM_HEIGHT) ? longint'(plan.wm_height) : MAX_WM_HEIGHT;
    if (wx < lx && wy < ly) return int'(wy * MAX_WM_WIDTH + wx);
    return -1;
  endfunction

  // How many source columns (or rows) past the origin still map into the image.
  function automatic int reach(logic [SIZE_BITS-1:0] size, logic [STEP_BITS-1:0] step,
                               int max_size);
    longint lim;
    longint r;
    lim = (size < max_size) ? longint'(size) : max_size;
    if (step == '0) return 64;
    r = lim * 65536 / longint'(step) + 2;
    return (r > 4095) ? 4095 : int'(r);
  endfunction

  // Presents one request, with random gaps ahead of it, and waits for acceptance.
  task automatic drive_request(logic action, logic [COORD_BITS-1:0] col,
                               logic [COORD_BITS-1:0] row, logic [PIX_BITS-1:0] rgb);
    while (!calm && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16], row, col};
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
  endtask

  // Sends a request; a process request that would read an empty entry gets a load first.
  task automatic send_request(logic action, logic [COORD_BITS-1:0] col,
                              logic [COORD_BITS-1:0] row, logic [PIX_BITS-1:0] rgb);
    int idx;
    if (action == ACT_PROCESS) begin
      idx = stored_index(col, row);
      if (idx >= 0 && !written_map[ADDR_BITS'(idx)]) begin
        written_map[ADDR_BITS'(idx)] = 1'b1;
        drive_request(ACT_LOAD, COORD_BITS'(idx % MAX_WM_WIDTH), COORD_BITS'(idx / MAX_WM_WIDTH),
                      random_colour());
      end
    end else if (col < MAX_WM_WIDTH && row < MAX_WM_HEIGHT) begin
      written_map[ADDR_BITS'(32'(row) * MAX_WM_WIDTH + 32'(col))] = 1'b1;
    end
    drive_request(action, col, row, rgb);
  endtask

  // Stops the sender until every result is in, then lets the pipeline settle.
  task automatic drain(int settle);
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // One APB write; bits above the register width may carry random junk.
  task automatic write_register(logic [REG_IDX_BITS-1:0] idx, logic [31:0] value, int width);
    logic [31:0] junk;
    junk = ($urandom_range(1) == 1) ? ($urandom << width) : 32'd0;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value | junk;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic write_placement(cfg_t c);
    write_register(REG_OFFSET_X, 32'(c.offset_x), COORD_BITS);
    write_register(REG_OFFSET_Y, 32'(c.offset_y), COORD_BITS);
    write_register(REG_WM_WIDTH, 32'(c.wm_width), SIZE_BITS);
    write_register(REG_WM_HEIGHT, 32'(c.wm_height), SIZE_BITS);
    write_register(REG_X_STEP, 32'(c.x_step), STEP_BITS);
    write_register(REG_Y_STEP, 32'(c.y_step), STEP_BITS);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    plan = c;
  endtask

  // Random request: mostly process requests aimed at the placed region.
  task automatic send_random_item();
    logic [COORD_BITS:0] col;
    logic [COORD_BITS:0] row;
    if ($urandom_range(99) < 12) begin
      if ($urandom_range(4) == 0) begin
        send_request(ACT_LOAD, COORD_BITS'($urandom_range(4095)), COORD_BITS'($urandom_range(4095)),
                     random_colour());
      end else begin
        send_request(ACT_LOAD, COORD_BITS'($urandom_range(MAX_WM_WIDTH - 1)),
                     COORD_BITS'($urandom_range(MAX_WM_HEIGHT - 1)), random_colour());
      end
    end else begin
      if ($urandom_range(99) < 75) begin
        col = (COORD_BITS + 1)'(32'(plan.offset_x) +
                                $urandom_range(reach(plan.wm_width, plan.x_step, MAX_WM_WIDTH)));
        row = (COORD_BITS + 1)'(32'(plan.offset_y) +
                                $urandom_range(reach(plan.wm_height, plan.y_step, MAX_WM_HEIGHT)));
        if (col > 4095) col = (COORD_BITS + 1)'($urandom_range(4095));
        if (row > 4095) row = (COORD_BITS + 1)'($urandom_range(4095));
      end else begin
        col = (COORD_BITS + 1)'($urandom_range(4095));
        row = (COORD_BITS + 1)'($urandom_range(4095));
      end
      send_request(ACT_PROCESS, col[COORD_BITS-1:0], row[COORD_BITS-1:0], random_colour());
    end
  endtask

  // One configuration phase: settle, program, then random traffic with a pause midway.
  task automatic run_phase(cfg_t c, int count);
    drain(DRAIN_CYCLES);
    write_placement(c);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain(0);
      send_random_item();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = ACT_LOAD;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    plan        = make_placement(0, 0, RST_WM_SIZE, RST_WM_SIZE, RST_STEP, RST_STEP);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: a 4 by 3 watermark placed at column 2, row 1.
    write_placement(make_placement(2, 1, 4, 3, 65536, 65536));
    send_request(ACT_LOAD, 0, 0, 24'hFFFFFF);
    send_request(ACT_LOAD, 1, 0, 24'h000000);
    send_request(ACT_LOAD, 2, 0, 24'h0180FE);
    send_request(ACT_LOAD, 3, 2, 24'h807F01);
    send_request(ACT_LOAD, 255, 255, 24'hAA55AA);
    // Loads outside the store are dropped.
    send_request(ACT_LOAD, 256, 0, 24'h123456);
    send_request(ACT_LOAD, 0, 256, 24'h654321);
    send_request(ACT_LOAD, 4095, 4095, 24'hFFFFFF);
    // Blend against white, pass through on the black key, blend with odd channels.
    send_request(ACT_PROCESS, 2, 1, 24'h000000);
    send_request(ACT_PROCESS, 2, 1, 24'hFFFFFF);
    send_request(ACT_PROCESS, 3, 1, 24'hFFFFFF);
    send_request(ACT_PROCESS, 4, 1, 24'hFF00FF);
    send_request(ACT_PROCESS, 5, 3, 24'h7F80FF);
    // Left of the origin, above it, past the used width and height, far corner.
    send_request(ACT_PROCESS, 1, 1, 24'h112233);
    send_request(ACT_PROCESS, 2, 0, 24'h445566);
    send_request(ACT_PROCESS, 6, 1, 24'h778899);
    send_request(ACT_PROCESS, 2, 4, 24'hAABBCC);
    send_request(ACT_PROCESS, 0, 0, 24'hFFFFFF);
    send_request(ACT_PROCESS, 4095, 4095, 24'h000000);

    // Identity placement, then the far corner with the largest steps.
    run_phase(make_placement(0, 0, 256, 256, 65536, 65536), 75);
    run_phase(make_placement(4095, 4095, 256, 256, 24'hFFFFFF, 24'hFFFFFF), 40);
    // Zero width: nothing may blend.
    run_phase(make_placement($urandom_range(40), $urandom_range(40), 0, 5, 65536, 65536), 40);
    // Long stretch with both sides always ready.
    calm = 1'b1;
    run_phase(random_placement(), 90);
    calm = 1'b0;
    // Steps below one, including zero.
    run_phase(make_placement($urandom_range(100), $urandom_range(100), 12, 9, 0, 32768), 55);
    // Sizes above the store limit are clipped to it.
    run_phase(make_placement($urandom_range(100), $urandom_range(100), 511, 511, 98304, 65536),
              70);
    for (int p = 0; p < 4; p++) begin
      run_phase(random_placement(), 60);
    end

    drain(DRAIN_CYCLES);
    if (fail_count == 0 && pending_results == 0) begin
      $display("[keyed_watermark_blend] OK");
    end else begin
      $display("[keyed_watermark_blend] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/kwb_pkg.sv
hdl/kwb_ram.sv
hdl/kwb_cfg.sv
hdl/kwb_map.sv
hdl/keyed_watermark_blend.sv
dv/kwb_blend_checker.sv
dv/keyed_watermark_blend_tb.sv
